>>> rtl/rfps_pkg.sv
// Package for the rocket flight phase sequencer.
// Holds field widths, phase and register codes and the shared struct types.
// No dependencies; every other RTL file imports it.
`default_nettype none

package rfps_pkg;

   // Field widths of the sample and result beats.
   localparam int TIME_W  = 32;
   localparam int ALT_W   = 25;
   localparam int VEL_W   = 18;
   localparam int ACC_W   = 18;
   localparam int PHASE_W = 3;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int DELAY_W     = 20;
   localparam int ALT_LIM_W   = 20;
   localparam int SPD_LIM_W   = 17;
   localparam int ACC_LIM_W   = 17;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_BRAKES_ENABLED  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEPLOY_DELAY    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RETRACT_DELAY   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ALT_LIMIT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_LIMIT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL_LIMIT     = 3'd5;

   // Register reset values.
   localparam logic [DELAY_W-1:0]   DEPLOY_DELAY_RST  = 20'd6000;
   localparam logic [DELAY_W-1:0]   RETRACT_DELAY_RST = 20'd20000;
   localparam logic [ALT_LIM_W-1:0] ALT_LIMIT_RST     = 20'd1000;
   localparam logic [SPD_LIM_W-1:0] SPEED_LIMIT_RST   = 17'd500;
   localparam logic [ACC_LIM_W-1:0] ACCEL_LIMIT_RST   = 17'd1500;

   // Backup margin after the retract delay before recovery is forced.
   localparam logic [DELAY_W:0] BACKUP_MS = 21'd1000;

   // Flight phases.
   localparam logic [PHASE_W-1:0] PH_PRELAUNCH  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LAUNCHED   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_DEPLOYING  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DEPLOYED   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_RETRACTING = 3'd4;
   localparam logic [PHASE_W-1:0] PH_RETRACTED  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_RECOVERY   = 3'd6;
   localparam logic [PHASE_W-1:0] PH_LANDED     = 3'd7;

   typedef struct packed {
      logic                 brakes_enabled;
      logic [DELAY_W-1:0]   deploy_delay_ms;
      logic [DELAY_W-1:0]   retract_delay_ms;
      logic [ALT_LIM_W-1:0] launch_altitude_limit;
      logic [SPD_LIM_W-1:0] launch_speed_limit;
      logic [ACC_LIM_W-1:0] launch_accel_limit;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]        sample_time_ms;
      logic signed [ALT_W-1:0]  altitude_cm;
      logic signed [VEL_W-1:0]  velocity_cm_s;
      logic signed [ACC_W-1:0]  accel_cm_s2;
   } sample_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [TIME_W-1:0]  launch_stamp_ms;
      logic               brake_cmd;
      logic               recovery_cmd;
   } seq_state_type;

endpackage

`default_nettype wire

>>> rtl/rfps_req_if.sv
// Sample channel interface: valid, ready and one sensor sample per beat.
// Depends on rfps_pkg for the field widths.
`default_nettype none

interface rfps_req_if import rfps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TIME_W-1:0]       sample_time_ms;
   logic signed [ALT_W-1:0] altitude_cm;
   logic signed [VEL_W-1:0] velocity_cm_s;
   logic signed [ACC_W-1:0] accel_cm_s2;

   modport source (output valid, sample_time_ms, altitude_cm, velocity_cm_s, accel_cm_s2,
                   input ready);
   modport sink   (input valid, sample_time_ms, altitude_cm, velocity_cm_s, accel_cm_s2,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/rfps_rsp_if.sv
// Result channel interface: valid, ready and the commands and phase per beat.
// Depends on rfps_pkg for the phase width.
`default_nettype none

interface rfps_rsp_if import rfps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               airbrake_deploy;
   logic               recovery_deploy;
   logic [PHASE_W-1:0] flight_phase;

   modport source (output valid, airbrake_deploy, recovery_deploy, flight_phase,
                   input ready);
   modport sink   (input valid, airbrake_deploy, recovery_deploy, flight_phase,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/rfps_phase_logic.sv
// Next-state logic of the flight sequencer for one sample.
// Pure combinational; depends on rfps_pkg for the phase codes and structs.
`default_nettype none

module rfps_phase_logic import rfps_pkg::*; (
   input  wire cfg_type       cfg,
   input  wire seq_state_type cur,
   input  wire sample_type    smp,
   output seq_state_type      nxt
);

   logic [TIME_W-1:0] elapsed;
   logic              apogee;
   logic              launch_hit;
   logic              deploy_due;
   logic              retract_due;
   logic              backup_due;
   logic [DELAY_W:0]  backup_limit;

   // Elapsed time since launch wraps modulo 2^32.
   assign elapsed = smp.sample_time_ms - cur.launch_stamp_ms;
   assign apogee  = (smp.velocity_cm_s <= $signed({VEL_W{1'b0}}));

   // Launch thresholds: signed samples against unsigned limits, one bit wider.
   always_comb begin
      launch_hit =
         ($signed({smp.altitude_cm[ALT_W-1], smp.altitude_cm}) >
          $signed({{(ALT_W+1-ALT_LIM_W){1'b0}}, cfg.launch_altitude_limit})) ||
         ($signed({smp.velocity_cm_s[VEL_W-1], smp.velocity_cm_s}) >
          $signed({{(VEL_W+1-SPD_LIM_W){1'b0}}, cfg.launch_speed_limit})) ||
         ($signed({smp.accel_cm_s2[ACC_W-1], smp.accel_cm_s2}) >
          $signed({{(ACC_W+1-ACC_LIM_W){1'b0}}, cfg.launch_accel_limit}));
   end

   // Time-since-launch compares.
   assign backup_limit = {1'b0, cfg.retract_delay_ms} + BACKUP_MS;
   assign deploy_due   = (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, cfg.deploy_delay_ms});
   assign retract_due  = (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, cfg.retract_delay_ms});
   assign backup_due   = (elapsed >= {{(TIME_W-DELAY_W-1){1'b0}}, backup_limit});

   // Phase transitions.
   always_comb begin
      nxt = cur;
      case (cur.phase)
         PH_PRELAUNCH: begin
            nxt.brake_cmd    = 1'b0;
            nxt.recovery_cmd = 1'b0;
            if (launch_hit) begin
               nxt.launch_stamp_ms = smp.sample_time_ms;
               nxt.phase           = PH_LAUNCHED;
            end
         end
         PH_LAUNCHED: begin
            nxt.brake_cmd = 1'b0;
            if (cfg.brakes_enabled && deploy_due) begin
               nxt.phase = PH_DEPLOYING;
            end else if (!cfg.brakes_enabled && apogee) begin
               nxt.recovery_cmd = 1'b1;
               nxt.phase        = PH_RECOVERY;
            end
         end
         PH_DEPLOYING: begin
            nxt.brake_cmd = 1'b1;
            nxt.phase     = PH_DEPLOYED;
         end
         PH_DEPLOYED: begin
            nxt.brake_cmd = 1'b1;
            if (apogee || retract_due) begin
               nxt.phase = PH_RETRACTING;
            end
         end
         PH_RETRACTING: begin
            nxt.brake_cmd = 1'b0;
            nxt.phase     = PH_RETRACTED;
         end
         PH_RETRACTED: begin
            nxt.brake_cmd = 1'b0;
            if (apogee || backup_due) begin
               nxt.recovery_cmd = 1'b1;
               nxt.phase        = PH_RECOVERY;
            end
         end
         PH_RECOVERY: begin
            nxt.brake_cmd    = 1'b0;
            nxt.recovery_cmd = 1'b1;
            if (smp.altitude_cm <= $signed({ALT_W{1'b0}})) begin
               nxt.phase = PH_LANDED;
            end
         end
         default: begin
            nxt.brake_cmd    = 1'b0;
            nxt.recovery_cmd = 1'b1;
            nxt.phase        = PH_LANDED;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/rocket_flight_phase_sequencer_top.sv
// Rocket flight phase sequencer, top level; uses rfps_pkg, the channel interfaces and
// rfps_phase_logic.
// A sample beat goes into the input register, then into the result register once that
// is free or drains; the result beat is offered from there. Throughput: one sample per
// cycle unless the result side stalls; the phase update is combinational. Reset
// (synchronous, active high) returns to prelaunch, clears the stamp and loads defaults.
`default_nettype none

module rocket_flight_phase_sequencer_top import rfps_pkg::*; (
   input  wire                   clock,
   input  wire                   reset,
   rfps_req_if.sink              req_chan,
   rfps_rsp_if.source            rsp_chan,
   input  wire                   csr_we,
   input  wire [CSR_INDEX_W-1:0] csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type       cfg_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   sample_type    smp_ff;
   logic          smp_valid_ff;
   logic          smp_advance;
   logic          rsp_valid_ff;
   logic          rsp_brake_ff;
   logic          rsp_recovery_ff;
   logic [PHASE_W-1:0] rsp_phase_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brakes_enabled        <= 1'b1;
         cfg_ff.deploy_delay_ms       <= DEPLOY_DELAY_RST;
         cfg_ff.retract_delay_ms      <= RETRACT_DELAY_RST;
         cfg_ff.launch_altitude_limit <= ALT_LIMIT_RST;
         cfg_ff.launch_speed_limit    <= SPEED_LIMIT_RST;
         cfg_ff.launch_accel_limit    <= ACCEL_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_BRAKES_ENABLED: cfg_ff.brakes_enabled        <= csr_wdata[0];
            REG_DEPLOY_DELAY:   cfg_ff.deploy_delay_ms       <= csr_wdata[DELAY_W-1:0];
            REG_RETRACT_DELAY:  cfg_ff.retract_delay_ms      <= csr_wdata[DELAY_W-1:0];
            REG_ALT_LIMIT:      cfg_ff.launch_altitude_limit <= csr_wdata[ALT_LIM_W-1:0];
            REG_SPEED_LIMIT:    cfg_ff.launch_speed_limit    <= csr_wdata[SPD_LIM_W-1:0];
            REG_ACCEL_LIMIT:    cfg_ff.launch_accel_limit    <= csr_wdata[ACC_LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // The input register moves on whenever the result register is free or drains.
   assign smp_advance    = smp_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !smp_valid_ff || smp_advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         smp_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         smp_ff.sample_time_ms <= req_chan.sample_time_ms;
         smp_ff.altitude_cm    <= req_chan.altitude_cm;
         smp_ff.velocity_cm_s  <= req_chan.velocity_cm_s;
         smp_ff.accel_cm_s2    <= req_chan.accel_cm_s2;
      end
   end

   rfps_phase_logic u_phase_logic (
      .cfg (cfg_ff),
      .cur (state_ff),
      .smp (smp_ff),
      .nxt (state_in)
   );

   // Sequencer state advances once per sample as it enters the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= PH_PRELAUNCH;
         state_ff.launch_stamp_ms <= '0;
         state_ff.brake_cmd       <= 1'b0;
         state_ff.recovery_cmd    <= 1'b0;
      end else if (smp_advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (smp_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (smp_advance) begin
         rsp_brake_ff    <= state_in.brake_cmd;
         rsp_recovery_ff <= state_in.recovery_cmd;
         rsp_phase_ff    <= state_in.phase;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.airbrake_deploy = rsp_brake_ff;
   assign rsp_chan.recovery_deploy = rsp_recovery_ff;
   assign rsp_chan.flight_phase    = rsp_phase_ff;

   // Airbrakes are commanded out only while deployed or just starting to retract.
   a_brake_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.brake_cmd |->
         (state_ff.phase == PH_DEPLOYED || state_ff.phase == PH_RETRACTING))
      else $error("airbrake command outside the deployed phases");

   // Recovery is commanded only in the recovery and landed phases.
   a_recovery_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.recovery_cmd |->
         (state_ff.phase == PH_RECOVERY || state_ff.phase == PH_LANDED))
      else $error("recovery command outside the recovery phases");

   // Landed is final until reset.
   a_landed_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_LANDED) |=> (state_ff.phase == PH_LANDED))
      else $error("left the landed phase");

   // The state changes only when a sample moves into the result register.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !smp_advance |=> $stable(state_ff))
      else $error("sequencer state changed without a sample");

   // A held sample is never dropped while the result side stalls.
   a_sample_kept: assert property (@(posedge clock) disable iff (reset)
      (smp_valid_ff && !smp_advance) |=> smp_valid_ff)
      else $error("stalled sample lost");

endmodule

`default_nettype wire

>>> bench/rfps_flight_checker.sv
// Scoreboard for the rocket flight phase sequencer: mirrors the registers, predicts
// the commands and phase for each sample beat, and compares them with the result beats.
// Depends on rfps_pkg, rfps_req_if and rfps_rsp_if.
`default_nettype none

module rfps_flight_checker import rfps_pkg::*; (
   input  wire                   clock,
   input  wire                   reset,
   rfps_req_if                   req_chan,
   rfps_rsp_if                   rsp_chan,
   input  wire                   csr_we,
   input  wire [CSR_INDEX_W-1:0] csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata,
   output int                    fail_count,
   output int                    outstanding,
   output logic [7:0]            phases_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic               airbrake_deploy;
      logic               recovery_deploy;
      logic [PHASE_W-1:0] flight_phase;
   } flight_cmd_type;

   // Mirror of the registers and of the sequencer state.
   cfg_type        regs;
   seq_state_type  seq;
   flight_cmd_type expected_cmds[$];

   // Advances the mirrored sequencer by one sample and returns the commands it yields.
   function automatic flight_cmd_type advance_phase(input sample_type smp);
      logic [TIME_W-1:0] elapsed;
      longint            since_ms;
      logic              apogee;
      logic              liftoff;
      flight_cmd_type    cmd;
      // Elapsed time wraps modulo 2^32 and is read as unsigned.
      elapsed  = smp.sample_time_ms - seq.launch_stamp_ms;
      since_ms = longint'(elapsed);
      apogee   = ($signed(smp.velocity_cm_s) <= 0);
      liftoff  = (longint'($signed(smp.altitude_cm)) > longint'(regs.launch_altitude_limit)) ||
                 (longint'($signed(smp.velocity_cm_s)) > longint'(regs.launch_speed_limit)) ||
                 (longint'($signed(smp.accel_cm_s2)) > longint'(regs.launch_accel_limit));
      case (seq.phase)
         PH_PRELAUNCH: begin
            seq.brake_cmd    = 1'b0;
            seq.recovery_cmd = 1'b0;
            if (liftoff) begin
               seq.launch_stamp_ms = smp.sample_time_ms;
               seq.phase           = PH_LAUNCHED;
            end
         end
         PH_LAUNCHED: begin
            // The brake enable is only looked at here.
            seq.brake_cmd = 1'b0;
            if (regs.brakes_enabled && since_ms >= longint'(regs.deploy_delay_ms)) begin
               seq.phase = PH_DEPLOYING;
            end else if (!regs.brakes_enabled && apogee) begin
               seq.recovery_cmd = 1'b1;
               seq.phase        = PH_RECOVERY;
            end
         end
         PH_DEPLOYING: begin
            seq.brake_cmd = 1'b1;
            seq.phase     = PH_DEPLOYED;
         end
         PH_DEPLOYED: begin
            seq.brake_cmd = 1'b1;
            if (apogee || since_ms >= longint'(regs.retract_delay_ms)) begin
               seq.phase = PH_RETRACTING;
            end
         end
         PH_RETRACTING: begin
            seq.brake_cmd = 1'b0;
            seq.phase     = PH_RETRACTED;
         end
         PH_RETRACTED: begin
            seq.brake_cmd = 1'b0;
            if (apogee ||
                since_ms >= longint'(regs.retract_delay_ms) + longint'(BACKUP_MS)) begin
               seq.recovery_cmd = 1'b1;
               seq.phase        = PH_RECOVERY;
            end
         end
         PH_RECOVERY: begin
            seq.brake_cmd    = 1'b0;
            seq.recovery_cmd = 1'b1;
            if ($signed(smp.altitude_cm) <= 0) begin
               seq.phase = PH_LANDED;
            end
         end
         default: begin
            // Landed is final until reset.
            seq.brake_cmd    = 1'b0;
            seq.recovery_cmd = 1'b1;
            seq.phase        = PH_LANDED;
         end
      endcase
      cmd.airbrake_deploy = seq.brake_cmd;
      cmd.recovery_deploy = seq.recovery_cmd;
      cmd.flight_phase    = seq.phase;
      return cmd;
   endfunction

   // Watch both channels and the register port at every rising edge.
   always @(posedge clock) begin
      flight_cmd_type want;
      flight_cmd_type got;
      sample_type     smp;
      if (reset) begin
         regs.brakes_enabled        = 1'b1;
         regs.deploy_delay_ms       = DEPLOY_DELAY_RST;
         regs.retract_delay_ms      = RETRACT_DELAY_RST;
         regs.launch_altitude_limit = ALT_LIMIT_RST;
         regs.launch_speed_limit    = SPEED_LIMIT_RST;
         regs.launch_accel_limit    = ACCEL_LIMIT_RST;
         seq.phase           = PH_PRELAUNCH;
         seq.launch_stamp_ms = '0;
         seq.brake_cmd       = 1'b0;
         seq.recovery_cmd    = 1'b0;
         expected_cmds.delete();
         phases_seen = '0;
         fail_count  = 0;
         outstanding <= 0;
      end else begin
         // A result beat is checked against the oldest prediction first, so that a
         // beat arriving with nothing pending cannot be masked by a new sample.
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.airbrake_deploy = rsp_chan.airbrake_deploy;
            got.recovery_deploy = rsp_chan.recovery_deploy;
            got.flight_phase    = rsp_chan.flight_phase;
            if (expected_cmds.size() == 0) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("%0t: result beat with none pending: brake %b recovery %b phase %0d",
                           $time, got.airbrake_deploy, got.recovery_deploy, got.flight_phase);
               end
               fail_count++;
            end else begin
               want = expected_cmds.pop_front();
               if (got.airbrake_deploy !== want.airbrake_deploy ||
                   got.recovery_deploy !== want.recovery_deploy ||
                   got.flight_phase !== want.flight_phase) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("%0t: expected brake %b recovery %b phase %0d, got %b %b %0d",
                              $time, want.airbrake_deploy, want.recovery_deploy,
                              want.flight_phase, got.airbrake_deploy, got.recovery_deploy,
                              got.flight_phase);
                  end
                  fail_count++;
               end
            end
         end

         // Each sample beat yields exactly one prediction.
         if (req_chan.valid && req_chan.ready) begin
            smp.sample_time_ms = req_chan.sample_time_ms;
            smp.altitude_cm    = req_chan.altitude_cm;
            smp.velocity_cm_s  = req_chan.velocity_cm_s;
            smp.accel_cm_s2    = req_chan.accel_cm_s2;
            want = advance_phase(smp);
            phases_seen[want.flight_phase] = 1'b1;
            expected_cmds.push_back(want);
         end

         // Register writes are masked to the register width; unknown indexes are dropped.
         if (csr_we) begin
            case (csr_index)
               REG_BRAKES_ENABLED: regs.brakes_enabled        = csr_wdata[0];
               REG_DEPLOY_DELAY:   regs.deploy_delay_ms       = csr_wdata[DELAY_W-1:0];
               REG_RETRACT_DELAY:  regs.retract_delay_ms      = csr_wdata[DELAY_W-1:0];
               REG_ALT_LIMIT:      regs.launch_altitude_limit = csr_wdata[ALT_LIM_W-1:0];
               REG_SPEED_LIMIT:    regs.launch_speed_limit    = csr_wdata[SPD_LIM_W-1:0];
               REG_ACCEL_LIMIT:    regs.launch_accel_limit    = csr_wdata[ACC_LIM_W-1:0];
               default: ;
            endcase
         end

         outstanding <= expected_cmds.size();
      end
   end

endmodule

`default_nettype wire

>>> bench/rocket_flight_phase_sequencer_top_tb.sv
// Testbench top for the rocket flight phase sequencer: clock, reset, sample and
// register stimulus that walks one flight through all phases, and the verdict.
// Depends on rfps_pkg, rfps_req_if, rfps_rsp_if, rfps_flight_checker and the block.
`default_nettype none

module rocket_flight_phase_sequencer_top_tb import rfps_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CYCLE_LIMIT  = 1_000_000;
   localparam int     DRAIN_CYCLES = 6;
   localparam int     DELAY_ALL    = (1 << DELAY_W) - 1;
   localparam longint ALT_MIN      = -(longint'(1) << (ALT_W - 1));
   localparam longint ALT_MAX      = (longint'(1) << (ALT_W - 1)) - 1;
   localparam longint VEL_MIN      = -(longint'(1) << (VEL_W - 1));
   localparam longint VEL_MAX      = (longint'(1) << (VEL_W - 1)) - 1;
   localparam longint ACC_MIN      = -(longint'(1) << (ACC_W - 1));
   localparam longint ACC_MAX      = (longint'(1) << (ACC_W - 1)) - 1;

   // Indexes that map to no register.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     outstanding;
   logic [7:0]             phases_seen;
   int                     samples_sent = 0;
   int                     reg_writes   = 0;
   int                     cycle_count  = 0;
   logic                   calm = 1'b0;

   rfps_req_if req_chan ();
   rfps_rsp_if rsp_chan ();

   rocket_flight_phase_sequencer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rfps_flight_checker flight_watch (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .phases_seen (phases_seen)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long; none in calm stretches.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99, 0);
      if (calm || roll < 55) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 8);
   endfunction

   function automatic longint rand_between(input longint lo, input longint hi);
      return lo + longint'($urandom_range(32'(hi - lo), 0));
   endfunction

   // Result side back-pressure.
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   // Offers one sample beat after a random gap and returns at the edge it is taken.
   task automatic send_sample(input logic [TIME_W-1:0] t, input longint alt,
                              input longint vel, input longint acc);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.sample_time_ms <= t;
      req_chan.altitude_cm    <= alt[ALT_W-1:0];
      req_chan.velocity_cm_s  <= vel[VEL_W-1:0];
      req_chan.accel_cm_s2    <= acc[ACC_W-1:0];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   // Stops offering samples and waits until every result has come back.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      calm = ($urandom_range(3, 0) == 0);
   endtask

   // One flight from the pad to touchdown, with register changes between stretches.
   initial begin
      logic [TIME_W-1:0] launch_ms;
      int                deploy_ms;
      int                retract_ms;
      longint            alt_lim;
      longint            spd_lim;
      longint            acc_lim;
      int                trigger;

      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= '0;
      csr_wdata               <= '0;
      req_chan.valid          <= 1'b0;
      req_chan.sample_time_ms <= '0;
      req_chan.altitude_cm    <= '0;
      req_chan.velocity_cm_s  <= '0;
      req_chan.accel_cm_s2    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Default limits: every field exactly at its limit, and the far extremes.
      send_sample(32'd0, 1000, 500, 1500);
      send_sample(32'hFFFF_FFFF, ALT_MIN, VEL_MIN, ACC_MIN);
      send_sample(32'h8000_0000, 0, 0, 0);
      send_sample(32'h7FFF_FFFF, 999, -1, 1499);
      settle();

      // All-ones writes; the 17-bit limits keep only their own width.
      write_reg(REG_ALT_LIMIT, '1);
      write_reg(REG_SPEED_LIMIT, '1);
      write_reg(REG_ACCEL_LIMIT, '1);
      write_reg(REG_UNUSED_6, CSR_DATA_W'($urandom));
      write_reg(REG_UNUSED_7, CSR_DATA_W'($urandom));
      send_sample(32'h5555_5555, 1048575, VEL_MAX, ACC_MAX);
      send_sample(32'hAAAA_AAAA, -1, VEL_MAX, 0);
      for (int i = 0; i < 180; i++) begin
         send_sample($urandom, rand_between(ALT_MIN, 1048575),
                     rand_between(VEL_MIN, VEL_MAX), rand_between(ACC_MIN, ACC_MAX));
      end
      settle();

      // Zero limits: anything not positive stays on the pad.
      write_reg(REG_ALT_LIMIT, '0);
      write_reg(REG_SPEED_LIMIT, '0);
      write_reg(REG_ACCEL_LIMIT, '0);
      send_sample(32'd1, 0, 0, 0);
      for (int i = 0; i < 100; i++) begin
         send_sample($urandom, rand_between(ALT_MIN, 0), rand_between(VEL_MIN, 0),
                     rand_between(ACC_MIN, 0));
      end
      settle();

      // Random limits; samples at or below them, then liftoff by one of the three.
      alt_lim = $urandom_range(1000000, 0);
      spd_lim = $urandom_range(100000, 0);
      acc_lim = $urandom_range(100000, 0);
      write_reg(REG_ALT_LIMIT, CSR_DATA_W'(alt_lim));
      write_reg(REG_SPEED_LIMIT, CSR_DATA_W'(spd_lim));
      write_reg(REG_ACCEL_LIMIT, CSR_DATA_W'(acc_lim));
      for (int i = 0; i < 150; i++) begin
         send_sample($urandom, rand_between(ALT_MIN, alt_lim), rand_between(VEL_MIN, spd_lim),
                     rand_between(ACC_MIN, acc_lim));
      end
      // Launch just short of the time wrap so that elapsed times roll over.
      launch_ms = 32'hFFFF_FFFF - $urandom_range(3000, 0);
      trigger   = $urandom_range(2, 0);
      send_sample(launch_ms, (trigger == 0) ? alt_lim + 1 : ALT_MIN,
                  (trigger == 1) ? spd_lim + 1 : VEL_MIN, (trigger == 2) ? acc_lim + 1 : 0);
      settle();

      // Launched with brakes off and still climbing: nothing moves.
      write_reg(REG_BRAKES_ENABLED, CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1));
      for (int i = 0; i < 150; i++) begin
         send_sample($urandom, rand_between(ALT_MIN, ALT_MAX), rand_between(1, VEL_MAX),
                     rand_between(ACC_MIN, ACC_MAX));
      end
      settle();

      // Brakes on with the longest deploy delay; apogee does not matter here.
      write_reg(REG_BRAKES_ENABLED, CSR_DATA_W'($urandom) | CSR_DATA_W'(1));
      write_reg(REG_DEPLOY_DELAY, '1);
      for (int i = 0; i < 120; i++) begin
         send_sample(launch_ms + $urandom_range(DELAY_ALL - 1, 0),
                     rand_between(ALT_MIN, ALT_MAX), rand_between(VEL_MIN, VEL_MAX),
                     rand_between(ACC_MIN, ACC_MAX));
      end
      settle();

      // Random deploy delay, then deploy at the exact delay, by a sample older than
      // the launch stamp, or by a zero delay.
      deploy_ms = $urandom_range(600000, 1);
      write_reg(REG_DEPLOY_DELAY, CSR_DATA_W'(deploy_ms));
      for (int i = 0; i < 100; i++) begin
         send_sample(launch_ms + $urandom_range(deploy_ms - 1, 0),
                     rand_between(ALT_MIN, ALT_MAX), rand_between(VEL_MIN, VEL_MAX),
                     rand_between(ACC_MIN, ACC_MAX));
      end
      trigger = $urandom_range(2, 0);
      if (trigger == 0) begin
         send_sample(launch_ms + deploy_ms, 5000, 1000, 0);
      end else if (trigger == 1) begin
         send_sample(launch_ms - $urandom_range(1000, 1), 5000, 1000, 0);
      end else begin
         settle();
         write_reg(REG_DEPLOY_DELAY, '0);
         send_sample(launch_ms, 5000, VEL_MIN, 0);
      end
      // Deploying passes on regardless of the sample.
      send_sample($urandom, rand_between(ALT_MIN, ALT_MAX), rand_between(VEL_MIN, VEL_MAX),
                  rand_between(ACC_MIN, ACC_MAX));
      settle();

      // Deployed: disabling the brakes now must not cut the sequence short.
      write_reg(REG_RETRACT_DELAY, '1);
      write_reg(REG_BRAKES_ENABLED, '0);
      for (int i = 0; i < 150; i++) begin
         send_sample(launch_ms + $urandom_range(DELAY_ALL - 1, 0),
                     rand_between(ALT_MIN, ALT_MAX), rand_between(1, VEL_MAX),
                     rand_between(ACC_MIN, ACC_MAX));
      end
      if ($urandom_range(1, 0) == 0) begin
         send_sample(launch_ms + $urandom_range(DELAY_ALL - 1, 0), 80000,
                     ($urandom_range(1, 0) == 0) ? 0 : rand_between(VEL_MIN, -1), 0);
      end else begin
         send_sample(launch_ms + DELAY_ALL, 80000, 200, 0);
      end
      // Retracting passes on regardless of the sample.
      send_sample($urandom, rand_between(ALT_MIN, ALT_MAX), rand_between(VEL_MIN, VEL_MAX),
                  rand_between(ACC_MIN, ACC_MAX));
      settle();

      // Retracted: wait out the backup margin past a new retract delay.
      retract_ms = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(600000, 0);
      write_reg(REG_RETRACT_DELAY, CSR_DATA_W'(retract_ms));
      for (int i = 0; i < 100; i++) begin
         send_sample(launch_ms + $urandom_range(retract_ms + 999, 0),
                     rand_between(ALT_MIN, ALT_MAX), rand_between(1, VEL_MAX),
                     rand_between(ACC_MIN, ACC_MAX));
      end
      if ($urandom_range(1, 0) == 0) begin
         send_sample(launch_ms + $urandom_range(retract_ms + 999, 0), 90000,
                     rand_between(VEL_MIN, 0), 0);
      end else begin
         send_sample(launch_ms + retract_ms + 1000, 90000, 50, 0);
      end
      settle();

      // Under the parachute until the altitude reaches zero or below.
      send_sample($urandom, 1, rand_between(VEL_MIN, VEL_MAX), rand_between(ACC_MIN, ACC_MAX));
      for (int i = 0; i < 150; i++) begin
         send_sample($urandom, rand_between(1, ALT_MAX), rand_between(VEL_MIN, VEL_MAX),
                     rand_between(ACC_MIN, ACC_MAX));
      end
      send_sample($urandom, ($urandom_range(1, 0) == 0) ? 0 : rand_between(ALT_MIN, -1),
                  rand_between(VEL_MIN, VEL_MAX), rand_between(ACC_MIN, ACC_MAX));
      settle();

      // Landed: any register setting and any sample leaves it there.
      write_reg(REG_BRAKES_ENABLED, CSR_DATA_W'($urandom));
      write_reg(REG_DEPLOY_DELAY, CSR_DATA_W'($urandom));
      write_reg(REG_RETRACT_DELAY, CSR_DATA_W'($urandom));
      write_reg(REG_ALT_LIMIT, CSR_DATA_W'($urandom));
      write_reg(REG_SPEED_LIMIT, CSR_DATA_W'($urandom));
      write_reg(REG_ACCEL_LIMIT, CSR_DATA_W'($urandom));
      for (int i = 0; i < 300; i++) begin
         send_sample($urandom, rand_between(ALT_MIN, ALT_MAX), rand_between(VEL_MIN, VEL_MAX),
                     rand_between(ACC_MIN, ACC_MAX));
      end
      settle();

      $display("Covered %0d sample beats and %0d register writes over one flight.",
               samples_sent, reg_writes);
      $display("Phases reached (landed..prelaunch): %b, mismatches: %0d",
               phases_seen, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
